// File: design/assert_macros.svh
// Assertion macros for the averaging block's top-level RTL file.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property that is checked only while reset is low.
`define BAVD_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bavd assertion failed");

// Clocked property that is checked during reset as well.
`define BAVD_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("bavd assertion failed");

`else

`define BAVD_ASSERT(name, clk, rst, prop)

`define BAVD_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

// File: design/bavd_pkg.sv
// Package for the block averaging unit: widths, op codes, states and structs.
// No dependencies; imported by every module of the block.
package bavd_pkg;

   localparam int MAX_SAMPLES = 25;
   localparam int PRESSURE_W  = 25;
   localparam int SUM_W       = 30;
   localparam int COUNT_W     = 5;
   localparam int DELTA_W     = 22;
   localparam int OP_W        = 2;
   localparam int PRODUCT_W   = PRESSURE_W + 4;
   localparam int SCALED_W    = PRODUCT_W - 8;
   localparam int DIV_STEPS   = SUM_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_RESET   = 12;

   typedef enum logic [OP_W-1:0] {
      OP_SAMPLE = 2'd0,
      OP_TICK   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_UNUSED = 2'd3
   } op_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_DIFF,
      ST_EMIT
   } back_state_type;

   typedef struct packed {
      op_code_type            op;
      logic [PRESSURE_W-1:0]  pressure;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: design/bavd_front.sv
// Front end of the averaging block: accepts request transfers and classifies them.
// Depends on bavd_pkg; feeds bavd_queue.
module bavd_front (
   input  logic                                req_push,
   input  logic [bavd_pkg::OP_W-1:0]           req_op,
   input  logic [bavd_pkg::PRESSURE_W-1:0]     req_pressure_q8,
   output logic                                req_full,
   input  bavd_pkg::queue_status_type          q_status,
   output logic                                q_wr_en,
   output bavd_pkg::cmd_type                   q_wr_data
);
   import bavd_pkg::*;

   op_code_type op_code;
   logic        accept;

   assign op_code  = op_code_type'(req_op);
   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;

   // The unused op code has no effect at all, so it never enters the queue.
   always_comb begin
      q_wr_en            = 1'b0;
      q_wr_data.op       = op_code;
      q_wr_data.pressure = '0;
      case (op_code)
         OP_SAMPLE: begin
            q_wr_en            = accept;
            q_wr_data.pressure = req_pressure_q8;
         end
         OP_TICK: begin
            q_wr_en = accept;
         end
         OP_CLEAR: begin
            q_wr_en = accept;
         end
         default: begin
            q_wr_en = 1'b0;
         end
      endcase
   end

endmodule

// File: design/bavd_queue.sv
// Short command queue between the front and back ends of the averaging block.
// Depends on bavd_pkg.
module bavd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  bavd_pkg::cmd_type          wr_data,
   input  logic                       rd_en,
   output bavd_pkg::cmd_type          rd_data,
   output bavd_pkg::queue_status_type status
);
   import bavd_pkg::*;

   cmd_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]    count_ff,  count_in;
   logic                   do_wr;
   logic                   do_rd;

   assign status.full  = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_wr        = wr_en && !status.full;
   assign do_rd        = rd_en && !status.empty;
   assign rd_data      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: design/bavd_back.sv
// Back end of the averaging block: block state, serial divider, delta scaling
// and the result register. Depends on bavd_pkg; fed by bavd_queue.
module bavd_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [bavd_pkg::COUNT_W-1:0]      samples_per_block,
   input  bavd_pkg::cmd_type                 cmd,
   input  logic                              cmd_empty,
   output logic                              cmd_pop,
   output logic                              rsp_valid,
   output logic [bavd_pkg::DELTA_W-1:0]      rsp_delta_pressure,
   output logic                              rsp_baseline_captured,
   input  logic                              rsp_pop
);
   import bavd_pkg::*;

   back_state_type           state_ff, state_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [PRESSURE_W-1:0]    base_ff, base_in;
   logic                     base_valid_ff, base_valid_in;
   logic [SUM_W-1:0]         quo_ff, quo_in;
   logic [COUNT_W-1:0]       rem_ff, rem_in;
   logic [COUNT_W-1:0]       divisor_ff, divisor_in;
   logic [DIV_CNT_W-1:0]     step_ff, step_in;
   logic [PRESSURE_W-1:0]    mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic                     cap_ff, cap_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DELTA_W-1:0]       rsp_delta_ff, rsp_delta_in;
   logic                     rsp_cap_ff, rsp_cap_in;

   logic [COUNT_W-1:0]       limit;
   logic [COUNT_W:0]         trial;
   logic                     trial_ge;
   logic [PRESSURE_W-1:0]    avg;
   logic [PRODUCT_W-1:0]     product;
   logic [SCALED_W-1:0]      scaled;
   logic                     emit_ok;
   logic                     div_last;

   assign limit    = (samples_per_block > COUNT_W'(MAX_SAMPLES)) ?
                     COUNT_W'(MAX_SAMPLES) : samples_per_block;
   assign trial    = {rem_ff, quo_ff[SUM_W-1]};
   assign trial_ge = (trial >= {1'b0, divisor_ff});
   assign avg      = quo_ff[PRESSURE_W-1:0];
   assign product  = (PRODUCT_W'(mag_ff) << 3) + (PRODUCT_W'(mag_ff) << 1);
   assign scaled   = product[PRODUCT_W-1:8];
   assign emit_ok  = !rsp_valid_ff || rsp_pop;
   assign div_last = (step_ff == DIV_CNT_W'(DIV_STEPS - 1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty && cmd.op == OP_TICK && count_ff != '0) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_last) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and handshake outputs.
   always_comb begin
      cmd_pop       = 1'b0;
      sum_in        = sum_ff;
      count_in      = count_ff;
      base_in       = base_ff;
      base_valid_in = base_valid_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      divisor_in    = divisor_ff;
      step_in       = step_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      cap_in        = cap_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_pop;
      rsp_delta_in  = rsp_delta_ff;
      rsp_cap_in    = rsp_cap_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd_pop = !cmd_empty;
            if (!cmd_empty) begin
               case (cmd.op)
                  OP_SAMPLE: begin
                     if (count_ff < limit) begin
                        sum_in   = sum_ff + SUM_W'(cmd.pressure);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_TICK: begin
                     if (count_ff != '0) begin
                        quo_in     = sum_ff;
                        rem_in     = '0;
                        divisor_in = count_ff;
                        step_in    = '0;
                        sum_in     = '0;
                        count_in   = '0;
                     end
                  end
                  OP_CLEAR: begin
                     sum_in        = '0;
                     count_in      = '0;
                     base_in       = '0;
                     base_valid_in = 1'b0;
                  end
                  default: begin
                     sum_in = sum_ff;
                  end
               endcase
            end
         end
         ST_DIVIDE: begin
            // Restoring division, one quotient bit per cycle, MSB first.
            if (trial_ge) begin
               rem_in = COUNT_W'(trial - {1'b0, divisor_ff});
            end else begin
               rem_in = trial[COUNT_W-1:0];
            end
            quo_in  = {quo_ff[SUM_W-2:0], trial_ge};
            step_in = step_ff + 1'b1;
         end
         ST_DIFF: begin
            if (!base_valid_ff) begin
               base_in       = avg;
               base_valid_in = 1'b1;
               cap_in        = 1'b1;
               mag_in        = '0;
               neg_in        = 1'b0;
            end else if (avg >= base_ff) begin
               cap_in = 1'b0;
               mag_in = avg - base_ff;
               neg_in = 1'b0;
            end else begin
               cap_in = 1'b0;
               mag_in = base_ff - avg;
               neg_in = 1'b1;
            end
         end
         ST_EMIT: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_delta_in = neg_ff ? DELTA_W'(-DELTA_W'(scaled)) : DELTA_W'(scaled);
               rsp_cap_in   = cap_ff;
            end
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sum_ff        <= '0;
         count_ff      <= '0;
         base_ff       <= '0;
         base_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sum_ff        <= sum_in;
         count_ff      <= count_in;
         base_ff       <= base_in;
         base_valid_ff <= base_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      divisor_ff   <= divisor_in;
      step_ff      <= step_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      cap_ff       <= cap_in;
      rsp_delta_ff <= rsp_delta_in;
      rsp_cap_ff   <= rsp_cap_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_delta_pressure    = rsp_delta_ff;
   assign rsp_baseline_captured = rsp_cap_ff;

endmodule

// File: design/block_average_baseline_delta.sv
// Top level of the pressure block averaging unit with baseline delta.
// Depends on bavd_pkg, bavd_front, bavd_queue, bavd_back and assert_macros.svh.
//
// The request channel behaves like a queue write port: a transfer happens on a
// rising edge with req_push high and req_full low. req_op selects a pressure
// sample, an output tick or a baseline-and-block clear; op code 3 is ignored.
// The response channel behaves like a queue read port: while rsp_empty is low
// the result is on rsp_delta_pressure and rsp_baseline_captured, and a
// transfer happens on a rising edge with rsp_pop high.
// The csr channel writes samples_per_block; csr_ready is always high, and
// writes are expected only while the block is idle.
// Timing: while the back end is idle, samples and clears retire at one per cycle
// from the four-entry command queue. A tick on a non-empty block takes the back
// end through the serial divider (one quotient bit per cycle), the baseline
// compare and the result register before it returns to idle.
// Reset (synchronous, active high) empties the queue and result register,
// clears the block and baseline and sets samples_per_block to 12.
// When the receiver stalls, one finished result is held; the back end keeps
// retiring samples and clears, and blocks only on the next tick's result.
// The command queue keeps accepting requests until it fills.
module block_average_baseline_delta (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [bavd_pkg::OP_W-1:0]           req_op,
   input  logic [bavd_pkg::PRESSURE_W-1:0]     req_pressure_q8,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [bavd_pkg::DELTA_W-1:0] rsp_delta_pressure,
   output logic                                rsp_baseline_captured,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bavd_pkg::COUNT_W-1:0]        csr_samples_per_block
);
   import bavd_pkg::*;
   `include "assert_macros.svh"

   // CSR, to be written by the user only while the block is idle; not enforced.
   logic [COUNT_W-1:0] samples_per_block_ff, samples_per_block_in;

   queue_status_type   q_status;
   logic               q_wr_en;
   cmd_type            q_wr_data;
   cmd_type            q_rd_data;
   logic               q_rd_en;
   logic               rsp_valid;
   logic [DELTA_W-1:0] delta;

   assign csr_ready            = 1'b1;
   assign samples_per_block_in = (csr_valid && csr_ready) ?
                                 csr_samples_per_block : samples_per_block_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         samples_per_block_ff <= COUNT_W'(CSR_RESET);
      end else begin
         samples_per_block_ff <= samples_per_block_in;
      end
   end

   // Front end: take request transfers and drop unused op codes.
   bavd_front u_front (
      .req_push        (req_push),
      .req_op          (req_op),
      .req_pressure_q8 (req_pressure_q8),
      .req_full        (req_full),
      .q_status        (q_status),
      .q_wr_en         (q_wr_en),
      .q_wr_data       (q_wr_data)
   );

   // Decoupling queue between the two halves.
   bavd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_wr_en),
      .wr_data (q_wr_data),
      .rd_en   (q_rd_en),
      .rd_data (q_rd_data),
      .status  (q_status)
   );

   // Back end: accumulate, divide, compare against the baseline and hold
   // the result until it is popped.
   bavd_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .samples_per_block     (samples_per_block_ff),
      .cmd                   (q_rd_data),
      .cmd_empty             (q_status.empty),
      .cmd_pop               (q_rd_en),
      .rsp_valid             (rsp_valid),
      .rsp_delta_pressure    (delta),
      .rsp_baseline_captured (rsp_baseline_captured),
      .rsp_pop               (rsp_pop)
   );

   assign rsp_empty          = !rsp_valid;
   assign rsp_delta_pressure = delta;

   // The queue can never report full and empty together.
   `BAVD_ASSERT(a_queue_flags, clock, reset, !(q_status.full && q_status.empty))

   // An accepted unused op code never reaches the queue.
   `BAVD_ASSERT(a_unused_dropped, clock, reset,
      (req_push && !req_full && req_op == OP_UNUSED) |-> !q_wr_en)

   // A result that captures the baseline always carries a zero delta.
   `BAVD_ASSERT(a_capture_zero, clock, reset,
      (!rsp_empty && rsp_baseline_captured) |-> (rsp_delta_pressure == '0))

   // The back end never pops the queue while it is empty.
   `BAVD_ASSERT(a_no_empty_pop, clock, reset, q_status.empty |-> !q_rd_en)

endmodule
